/* hw/rtl/lerp_pkg.sv */
`default_nettype none
package lerp_pkg;

	localparam int EVENT_SLOTS = 64;
	localparam int SLOT_W      = $clog2(EVENT_SLOTS);
	localparam int COUNT_W     = $clog2(EVENT_SLOTS + 1);

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_MESSAGE = 2'd0,
		CMD_START   = 2'd1,
		CMD_STOP    = 2'd2,
		CMD_ADVANCE = 2'd3
	} cmd_t;

	// Operations passed from the front end to the back end.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_LOOP  = 2'd2,
		OP_ADV   = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t            code;
		logic [SLOT_W-1:0]   addr;
		logic [31:0]         value;
		logic [23:0]         bytes;
		logic [1:0]          len;
	} op_t;

	// One stored event.
	typedef struct packed {
		logic [31:0] offset;
		logic [23:0] bytes;
		logic [1:0]  len;
	} slot_t;

endpackage
`default_nettype wire

/* hw/rtl/lerp_cmd_if.sv */
`default_nettype none
interface lerp_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] time_us;
	logic [23:0] msg_bytes;
	logic [1:0]  msg_len;

	modport source (output valid, command, time_us, msg_bytes, msg_len, input ready);
	modport sink (input valid, command, time_us, msg_bytes, msg_len, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lerp_evt_if.sv */
`default_nettype none
interface lerp_evt_if;
	logic        valid;
	logic        ready;
	logic [23:0] out_bytes;
	logic [1:0]  out_len;
	logic [31:0] event_offset;
	logic        last;

	modport source (output valid, out_bytes, out_len, event_offset, last, input ready);
	modport sink (input valid, out_bytes, out_len, event_offset, last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/loop_event_recorder_player_unit.sv */
// Loop event recorder and player.
// cmd (sink): one item per command: message, start, stop or advance, with the
//   stream time in microseconds (the playback delta for advance) and up to
//   three message bytes. evt (source): one item per replayed event, carrying
//   its bytes, length and stored offset; last marks the final event of an
//   advance. An advance with no event in its window yields no item.
// The front end records start time, recording state and table fill, turns
// each command into an operation and drops messages while not recording or
// once the 64-entry table is full. A two-entry queue lets it keep taking
// commands while the back end scans the table.
// A message, start or stop is written into the queue and takes effect once
// the idle back end pops it. An advance forms the sum when it is popped,
// sets the position in ST_ADV, then reads and checks each stored event in
// ST_RD and ST_CHK on every pass over the table (two passes when the window
// wraps) and flushes the last hit in ST_FLUSH; the event memory has one
// read port. A stalled receiver holds the output register and pauses the
// scan; commands are still taken until the queue fills. Reset empties the
// table, stops recording and zeroes loop length and play position.
`default_nettype none
module loop_event_recorder_player_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lerp_cmd_if.sink   cmd,
	lerp_evt_if.source evt
);
	import lerp_pkg::*;

	op_t  push_data;
	logic push_valid;
	logic push_ready;
	op_t  pop_data;
	logic pop_valid;
	logic pop_ready;

	// Accept and classify commands.
	lerp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decouple the front end from the table scan.
	lerp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Store events, advance the play position and replay the window.
	lerp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.evt       (evt)
	);

endmodule
`default_nettype wire

/* hw/rtl/lerp_front.sv */
`default_nettype none
module lerp_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lerp_cmd_if.sink          cmd,
	output lerp_pkg::op_t     push_data,
	output logic              push_valid,
	input  wire logic         push_ready
);
	import lerp_pkg::*;

	logic               rec_q;
	logic [31:0]        start_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               take;
	logic               has_room;
	logic [31:0]        rel_time;
	cmd_t               cmd_code;

	assign cmd.ready = push_ready;
	assign take      = cmd.valid && push_ready;
	assign cmd_code  = cmd_t'(cmd.command);
	assign has_room  = cnt_q < COUNT_W'(EVENT_SLOTS);
	assign rel_time  = cmd.time_us - start_q;

	// Classify the item into a back-end operation; drop unrecorded messages.
	always_comb begin
		push_data.addr  = cnt_q[SLOT_W-1:0];
		push_data.value = rel_time;
		push_data.bytes = cmd.msg_bytes;
		push_data.len   = cmd.msg_len;
		push_data.code  = OP_WRITE;
		push_valid      = 1'b0;
		case (cmd_code)
			CMD_MESSAGE: begin
				push_data.code = OP_WRITE;
				push_valid     = take && rec_q && has_room;
			end
			CMD_START: begin
				push_data.code = OP_CLEAR;
				push_valid     = take;
			end
			CMD_STOP: begin
				push_data.code = OP_LOOP;
				push_valid     = take;
			end
			CMD_ADVANCE: begin
				push_data.code  = OP_ADV;
				push_data.value = cmd.time_us;
				push_valid      = take;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q   <= 1'b0;
			start_q <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			case (cmd_code)
				CMD_MESSAGE: begin
					if (rec_q && has_room)
						cnt_q <= cnt_q + COUNT_W'(1);
				end
				CMD_START: begin
					cnt_q   <= '0;
					start_q <= cmd.time_us;
					rec_q   <= 1'b1;
				end
				CMD_STOP: begin
					rec_q <= 1'b0;
				end
				default: begin
					rec_q <= rec_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lerp_queue.sv */
`default_nettype none
module lerp_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lerp_pkg::op_t push_data,
	input  wire logic     push_valid,
	output logic          push_ready,
	output lerp_pkg::op_t pop_data,
	output logic          pop_valid,
	input  wire logic     pop_ready
);
	import lerp_pkg::*;

	op_t        mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = fill_q != 2'd2;
	assign pop_valid  = fill_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lerp_back.sv */
`default_nettype none
module lerp_back (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lerp_pkg::op_t pop_data,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	lerp_evt_if.source    evt
);
	import lerp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_RD,
		ST_CHK,
		ST_FLUSH
	} state_t;

	state_t             state_q;
	slot_t              mem [EVENT_SLOTS];
	slot_t              rd_q;
	slot_t              hold_q;
	slot_t              out_q;
	logic               hold_valid_q;
	logic               out_valid_q;
	logic               out_last_q;
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        loop_q;
	logic [31:0]        play_q;
	logic [31:0]        old_q;
	logic [32:0]        sum_q;
	logic               wrap_q;
	logic               pass_q;
	logic [SLOT_W-1:0]  idx_q;

	logic               do_pop;
	logic               out_free;
	logic               out_load;
	logic               wrap_now;
	logic [32:0]        sum_wrapped;
	logic [31:0]        new_pos;
	logic               t_ge;
	logic               t_le;
	logic               hit;
	logic               pass_end;

	assign pop_ready = state_q == ST_IDLE;
	assign do_pop    = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || evt.ready;

	// Move the held hit to the output on a new hit or at the end of the scan.
	assign out_load  = hold_valid_q && out_free &&
		((state_q == ST_CHK && hit) || state_q == ST_FLUSH);

	assign evt.valid        = out_valid_q;
	assign evt.out_bytes    = out_q.bytes;
	assign evt.out_len      = out_q.len;
	assign evt.event_offset = out_q.offset;
	assign evt.last         = out_last_q;

	// Wrap once at the loop length, saturate what still overflows.
	assign wrap_now    = (loop_q != 32'd0) && (sum_q >= {1'b0, loop_q});
	assign sum_wrapped = wrap_now ? sum_q - {1'b0, loop_q} : sum_q;
	assign new_pos     = sum_wrapped[32] ? 32'hFFFF_FFFF : sum_wrapped[31:0];

	// Window test; play_q already holds the new position during the scan.
	assign t_ge     = rd_q.offset >= old_q;
	assign t_le     = rd_q.offset <= play_q;
	assign hit      = wrap_q ? (pass_q ? (!t_ge && t_le) : t_ge) : (t_ge && t_le);
	assign pass_end = (COUNT_W'(idx_q) + COUNT_W'(1)) == count_q;

	always_ff @(posedge clk) begin
		if (do_pop && pop_data.code == OP_WRITE)
			mem[pop_data.addr] <= '{offset: pop_data.value, bytes: pop_data.bytes,
				len: pop_data.len};
		if (state_q == ST_RD)
			rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			loop_q       <= '0;
			play_q       <= '0;
			old_q        <= '0;
			sum_q        <= '0;
			wrap_q       <= 1'b0;
			pass_q       <= 1'b0;
			idx_q        <= '0;
			hold_q       <= '0;
			hold_valid_q <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_q       <= hold_q;
				out_last_q  <= state_q == ST_FLUSH;
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						case (pop_data.code)
							OP_WRITE: count_q <= COUNT_W'(pop_data.addr) + COUNT_W'(1);
							OP_CLEAR: begin
								count_q <= '0;
								loop_q  <= '0;
								play_q  <= '0;
							end
							OP_LOOP: begin
								loop_q <= pop_data.value;
								play_q <= '0;
							end
							OP_ADV: begin
								sum_q   <= {1'b0, play_q} + {1'b0, pop_data.value};
								state_q <= ST_ADV;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADV: begin
					wrap_q  <= wrap_now;
					old_q   <= play_q;
					play_q  <= new_pos;
					pass_q  <= 1'b0;
					idx_q   <= '0;
					state_q <= (count_q == '0) ? ST_FLUSH : ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// Hold while the previous hit cannot move to the output.
					if (!(hit && hold_valid_q && !out_free)) begin
						if (hit) begin
							hold_q       <= rd_q;
							hold_valid_q <= 1'b1;
						end
						if (pass_end) begin
							idx_q <= '0;
							if (wrap_q && !pass_q) begin
								pass_q  <= 1'b1;
								state_q <= ST_RD;
							end else begin
								state_q <= ST_FLUSH;
							end
						end else begin
							idx_q   <= idx_q + SLOT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_FLUSH: begin
					if (!hold_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lerp_pkg::*;

	// Stimulus budget and run limits.
	localparam int ITEM_TARGET  = 430;
	localparam int MAX_GAP      = 14;
	// An advance over a full table walks it at most twice; the two-entry
	// command queue can stack up to three such walks with no handshake in between.
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 3 * (4 * EVENT_SLOTS + 3) + 2 * MAX_GAP;

	// Expected replay results and a private copy of the recorder state.
	class replay_scoreboard;
		typedef struct packed {
			logic [23:0] msg;
			logic [1:0]  size;
			logic [31:0] offset;
			logic        tail;
		} replay_t;

		logic [31:0]        slot_offset [EVENT_SLOTS];
		logic [23:0]        slot_msg    [EVENT_SLOTS];
		logic [1:0]         slot_size   [EVENT_SLOTS];
		logic [COUNT_W-1:0] fill;
		bit                 recording;
		logic [31:0]        rec_start;
		logic [31:0]        loop_len;
		logic [31:0]        position;
		replay_t            pending [$];
		int                 errors;

		function new();
			fill      = '0;
			recording = 1'b0;
			rec_start = '0;
			loop_len  = '0;
			position  = '0;
			errors    = 0;
		endfunction

		// Replay window of one advance; queue its hits in emission order.
		function void predict_advance(logic [31:0] delta);
			logic [32:0] sum;
			logic [31:0] oldp;
			logic [31:0] newp;
			bit          wrapped;
			bit          taken [EVENT_SLOTS];
			int          hits [$];
			replay_t     r;
			oldp    = position;
			sum     = {1'b0, oldp} + {1'b0, delta};
			wrapped = (loop_len != 0) && (sum >= {1'b0, loop_len});
			if (wrapped)
				sum = sum - {1'b0, loop_len};
			newp = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			for (int i = 0; i < EVENT_SLOTS; i++)
				taken[i] = 1'b0;
			if (wrapped) begin
				// Tail of the loop first, then the head up to the new position.
				for (int i = 0; i < fill; i++)
					if (slot_offset[i] >= oldp) begin
						taken[i] = 1'b1;
						hits = {hits, i};
					end
				for (int i = 0; i < fill; i++)
					if (!taken[i] && slot_offset[i] <= newp)
						hits = {hits, i};
			end else begin
				for (int i = 0; i < fill; i++)
					if (slot_offset[i] >= oldp && slot_offset[i] <= newp)
						hits = {hits, i};
			end
			foreach (hits[k]) begin
				r.msg    = slot_msg[hits[k]];
				r.size   = slot_size[hits[k]];
				r.offset = slot_offset[hits[k]];
				r.tail   = (k == hits.size() - 1);
				pending  = {pending, r};
			end
			position = newp;
		endfunction

		function void note_command(cmd_t op, logic [31:0] t, logic [23:0] b, logic [1:0] l);
			case (op)
				CMD_MESSAGE: begin
					if (recording && fill < EVENT_SLOTS) begin
						slot_offset[fill] = t - rec_start;
						slot_msg[fill]    = b;
						slot_size[fill]   = l;
						fill              = fill + 1'b1;
					end
				end
				CMD_START: begin
					fill      = '0;
					loop_len  = '0;
					position  = '0;
					rec_start = t;
					recording = 1'b1;
				end
				CMD_STOP: begin
					recording = 1'b0;
					loop_len  = t - rec_start;
					position  = '0;
				end
				CMD_ADVANCE: predict_advance(t);
			endcase
		endfunction

		function void check_replay(logic [23:0] b, logic [1:0] l, logic [31:0] o, logic lst);
			replay_t r;
			if (pending.size() == 0) begin
				$error("replay item with none expected: bytes %h len %0d offset %h last %b",
					b, l, o, lst);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (b !== r.msg) begin
				$error("out_bytes: expected %h, got %h", r.msg, b);
				errors++;
			end
			if (l !== r.size) begin
				$error("out_len: expected %0d, got %0d", r.size, l);
				errors++;
			end
			if (o !== r.offset) begin
				$error("event_offset: expected %h, got %h", r.offset, o);
				errors++;
			end
			if (lst !== r.tail) begin
				$error("last: expected %b, got %b", r.tail, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lerp_cmd_if cmd_ch ();
	lerp_evt_if evt_ch ();

	loop_event_recorder_player_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.evt    (evt_ch)
	);

	replay_scoreboard board;
	int               items_sent;
	// Quiet flags switch off the random gaps for a whole phase.
	bit               send_quiet;
	bit               take_quiet;
	int unsigned      idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Present one command at a falling edge and hold it until the block takes it.
	// Returns at the falling edge after acceptance, so the next call may drive at once.
	task automatic send_command(cmd_t op, logic [31:0] t, logic [23:0] b, logic [1:0] l);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.command   <= op;
		cmd_ch.time_us   <= t;
		cmd_ch.msg_bytes <= b;
		cmd_ch.msg_len   <= l;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		// Dropped messages do not count toward the budget.
		if (!(op == CMD_MESSAGE && !(board.recording && board.fill < EVENT_SLOTS)))
			items_sent++;
		board.note_command(op, t, b, l);
		@(negedge clk);
	endtask

	function automatic logic [1:0] pick_len();
		// Zero length is stored as given; keep it rare.
		return ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
	endfunction

	// One recording session: start, messages at rising offsets (sometimes out of order),
	// usually a stop, then a handful of advances with deltas sized against the loop.
	task automatic run_session(int n_msgs);
		logic [31:0] t0;
		logic [31:0] cur;
		logic [31:0] off;
		logic [31:0] span;
		logic [31:0] delta;
		int          n_adv;
		int          r;
		// Start near the top of the time range now and then to exercise offset wrap.
		t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 32'hFFF)
			: $urandom;
		send_command(CMD_START, t0, 24'($urandom), pick_len());
		cur = '0;
		for (int k = 0; k < n_msgs; k++) begin
			cur = cur + $urandom_range(0, 400);
			off = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cur) : cur;
			send_command(CMD_MESSAGE, t0 + off, 24'($urandom), pick_len());
		end
		span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur)
			: cur + $urandom_range(0, 300);
		// Leave the stop out once in a while: advances then run with a zero loop length.
		if ($urandom_range(0, 5) != 0)
			send_command(CMD_STOP, t0 + span, 24'($urandom), pick_len());
		n_adv = $urandom_range(1, 8);
		for (int k = 0; k < n_adv; k++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				delta = '0;
			else if (r == 1)
				delta = $urandom;
			else if (r <= 3)
				delta = span + $urandom_range(0, span);
			else
				delta = $urandom_range(0, span / 2 + 1);
			send_command(CMD_ADVANCE, delta, 24'($urandom), pick_len());
		end
	endtask

	// Result side: draw a stall per item, then take whatever the block offers.
	initial begin
		int stall;
		evt_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = take_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				evt_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			evt_ch.ready <= 1'b1;
			do @(posedge clk); while (evt_ch.valid !== 1'b1);
			board.check_replay(evt_ch.out_bytes, evt_ch.out_len, evt_ch.event_offset,
				evt_ch.last);
			@(negedge clk);
		end
	end

	// Watchdog: end the run when no item moves on either side for too long.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			    (evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int n;
		board            = new();
		items_sent       = 0;
		send_quiet       = 1'b0;
		take_quiet       = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.command   = CMD_MESSAGE;
		cmd_ch.time_us   = '0;
		cmd_ch.msg_bytes = '0;
		cmd_ch.msg_len   = '0;
		arst_n           = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Advance on an empty table with no loop set.
		send_command(CMD_ADVANCE, 32'd0, 24'h0, 2'd1);
		// Stop with no recording: loop length from the reset start time, then a wrap
		// over an empty table.
		send_command(CMD_STOP, 32'd5, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'd7, 24'h0, 2'd1);
		// Record across the 32-bit time wrap; byte extremes and a zero length.
		send_command(CMD_START, 32'hFFFF_FFF0, 24'hFFFFFF, 2'd3);
		send_command(CMD_MESSAGE, 32'hFFFF_FFF0, 24'hFFFFFF, 2'd3);
		send_command(CMD_MESSAGE, 32'h0000_0005, 24'h000000, 2'd1);
		send_command(CMD_MESSAGE, 32'h0000_0020, 24'h90407F, 2'd0);
		send_command(CMD_MESSAGE, 32'h0000_0040, 24'hA5A5A5, 2'd2);
		// Advance while still recording: zero loop length, plain window.
		send_command(CMD_ADVANCE, 32'h0000_0030, 24'h0, 2'd1);
		send_command(CMD_STOP, 32'h0000_0050, 24'h0, 2'd1);
		// Single-point window, plain window, wrapped window.
		send_command(CMD_ADVANCE, 32'h0000_0000, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'h0000_0030, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'h0000_0040, 24'h0, 2'd1);
		// Largest delta wraps; the next one also saturates the position.
		send_command(CMD_ADVANCE, 32'hFFFF_FFFF, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'hFFFF_FFFF, 24'h0, 2'd1);
		// Message outside recording is dropped; a second stop resets the loop.
		send_command(CMD_MESSAGE, 32'h0000_0060, 24'h123456, 2'd3);
		send_command(CMD_STOP, 32'h0000_0010, 24'h0, 2'd2);
		send_command(CMD_ADVANCE, 32'h0000_0025, 24'h0, 2'd2);
		// Zero-length loop: no wrap ever, saturation on overflow.
		send_command(CMD_START, 32'd1000, 24'h0, 2'd1);
		send_command(CMD_STOP, 32'd1000, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'hFFFF_FFFF, 24'h0, 2'd1);
		send_command(CMD_ADVANCE, 32'd5, 24'h0, 2'd1);

		// Fill the table past its end, then advance over it.
		run_session(EVENT_SLOTS + 4);

		// Random part: mostly complete sessions, with bursts of raw commands between.
		while (items_sent < ITEM_TARGET) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			take_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 8) begin
				n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
					: $urandom_range(0, 12);
				run_session(n);
			end else begin
				repeat ($urandom_range(1, 5))
					send_command(cmd_t'($urandom_range(0, 3)), $urandom, 24'($urandom),
						2'($urandom_range(0, 3)));
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain: wait for every expected replay, then watch for strays.
		take_quiet = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/lerp_pkg.sv
hw/rtl/lerp_cmd_if.sv
hw/rtl/lerp_evt_if.sv
hw/rtl/lerp_front.sv
hw/rtl/lerp_queue.sv
hw/rtl/lerp_back.sv
hw/rtl/loop_event_recorder_player_unit.sv
bench/tb.sv
